FILE: src/lpv_pkg.sv
// Package for the email local-part validator: status codes, character
// constants, the checker state type and the special-character lookup.
// Depends on nothing; used by lpv_step, the top level and both bench files.
package lpv_pkg;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_EMPTY    = 4'd1;
	localparam logic [3:0] ST_NONASCII = 4'd2;
	localparam logic [3:0] ST_CTRL     = 4'd3;
	localparam logic [3:0] ST_QUOTE    = 4'd4;
	localparam logic [3:0] ST_DOT      = 4'd5;
	localparam logic [3:0] ST_DOTDOT   = 4'd6;
	localparam logic [3:0] ST_SPECIAL  = 4'd7;
	localparam logic [3:0] ST_FOLD     = 4'd8;
	localparam logic [3:0] ST_UNCLOSED = 4'd9;

	localparam logic [1:0] FOLD_NONE   = 2'd0;
	localparam logic [1:0] FOLD_WANTLF = 2'd1;
	localparam logic [1:0] FOLD_WANTWS = 2'd2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	typedef struct packed {
		logic       in_quote;
		logic       escape_pending;
		logic [1:0] fold_stage;
		logic       at_first_byte;
		logic       prev_was_dot;
		logic       stopped_by_nul;
		logic [3:0] error_code;
	} lpv_state_t;

	typedef struct packed {
		logic       has_result;
		logic [3:0] status;
	} lpv_result_t;

	localparam lpv_state_t STATE_RESET = '{
		in_quote:       1'b0,
		escape_pending: 1'b0,
		fold_stage:     FOLD_NONE,
		at_first_byte:  1'b1,
		prev_was_dot:   1'b0,
		stopped_by_nul: 1'b0,
		error_code:     ST_OK
	};

	function automatic logic is_special(input logic [7:0] c);
		logic r;
		case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C,
			8'h3B, 8'h3A, 8'h5C, 8'h5B, 8'h5D, 8'h20: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/lpv_in_if.sv
// Input channel of the validator: one byte of a local part per transaction.
// Depends on nothing.
interface lpv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_string;

	modport source (output valid, output data_byte, output last_byte,
		output empty_string, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input empty_string, output ready);
endinterface

FILE: src/lpv_out_if.sv
// Result channel of the validator: one status code per transaction.
// Depends on nothing.
interface lpv_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

FILE: src/lpv_step.sv
// Next-state and status logic for one byte of a local part.
// Depends on lpv_pkg.
module lpv_step (
	input  lpv_pkg::lpv_state_t  st,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 empty_string,
	output lpv_pkg::lpv_state_t  nxt,
	output lpv_pkg::lpv_result_t res
);

	lpv_pkg::lpv_state_t n;
	logic                first;
	logic                after_dot;

	always_comb begin
		n          = st;
		first      = st.at_first_byte;
		after_dot  = st.prev_was_dot;
		res.has_result = 1'b0;
		res.status     = lpv_pkg::ST_OK;

		if (empty_string) begin
			n              = lpv_pkg::STATE_RESET;
			res.has_result = 1'b1;
			res.status     = lpv_pkg::ST_EMPTY;
		end else begin
			// Once an error is latched or a NUL has been seen, bytes are ignored.
			if (st.error_code == lpv_pkg::ST_OK && !st.stopped_by_nul) begin
				n.at_first_byte = 1'b0;
				n.prev_was_dot  = 1'b0;
				if (st.fold_stage == lpv_pkg::FOLD_WANTLF) begin
					if (data_byte == lpv_pkg::CH_LF && !last_byte) begin
						n.fold_stage = lpv_pkg::FOLD_WANTWS;
					end else begin
						n.error_code = lpv_pkg::ST_FOLD;
					end
				end else if (st.fold_stage != lpv_pkg::FOLD_NONE) begin
					if (data_byte == lpv_pkg::CH_SP || data_byte == lpv_pkg::CH_HT) begin
						n.fold_stage = lpv_pkg::FOLD_NONE;
					end else begin
						n.error_code = lpv_pkg::ST_FOLD;
					end
				end else if (data_byte == lpv_pkg::CH_NUL) begin
					n.stopped_by_nul = 1'b1;
				end else if (data_byte[7]) begin
					n.error_code = lpv_pkg::ST_NONASCII;
				end else begin
					n.prev_was_dot = (data_byte == lpv_pkg::CH_DOT);
					if (!st.in_quote) begin
						if (data_byte[7:5] == 3'b000 || data_byte == lpv_pkg::CH_DEL) begin
							n.error_code = lpv_pkg::ST_CTRL;
						end else if (data_byte == lpv_pkg::CH_QUOTE) begin
							if (first || after_dot) begin
								n.in_quote = 1'b1;
							end else begin
								n.error_code = lpv_pkg::ST_QUOTE;
							end
						end else if (data_byte == lpv_pkg::CH_DOT) begin
							if (after_dot) begin
								n.error_code = lpv_pkg::ST_DOTDOT;
							end else if (first || last_byte) begin
								n.error_code = lpv_pkg::ST_DOT;
							end
						end else if (lpv_pkg::is_special(data_byte)) begin
							n.error_code = lpv_pkg::ST_SPECIAL;
						end
					end else if (st.escape_pending) begin
						n.escape_pending = 1'b0;
					end else if (data_byte == lpv_pkg::CH_QUOTE) begin
						n.in_quote = 1'b0;
					end else if (data_byte == lpv_pkg::CH_BSLASH) begin
						n.escape_pending = 1'b1;
					end else if (data_byte == lpv_pkg::CH_CR) begin
						if (last_byte) begin
							n.error_code = lpv_pkg::ST_FOLD;
						end else begin
							n.fold_stage = lpv_pkg::FOLD_WANTLF;
						end
					end
				end
			end

			if (last_byte) begin
				res.has_result = 1'b1;
				if (n.error_code != lpv_pkg::ST_OK) begin
					res.status = n.error_code;
				end else if (n.fold_stage != lpv_pkg::FOLD_NONE) begin
					res.status = lpv_pkg::ST_FOLD;
				end else if (n.in_quote) begin
					res.status = lpv_pkg::ST_UNCLOSED;
				end else begin
					res.status = lpv_pkg::ST_OK;
				end
				n = lpv_pkg::STATE_RESET;
			end
		end
		nxt = n;
	end

endmodule

FILE: src/email_local_part_validator_unit.sv
// Top level of the email local-part validator: input register, checker state,
// step logic and result register. Depends on lpv_pkg, lpv_in_if, lpv_out_if
// and lpv_step.
//
// Usage: bytes of a local part enter on the chars channel, one per
// transaction, with last_byte set on the final byte. A transaction with
// empty_string set stands for a local part with no bytes and always answers
// the empty status, dropping any partly checked local part. One status
// transaction leaves on the result channel for each final byte or empty item;
// other bytes give no result.
// A final byte is taken into the input register; the combinational step
// logic gives its status, which is stored in the result register and offered
// from there. Throughput: one byte per cycle while no blocked result holds
// the input register, as the state update between the two is combinational.
// When the result receiver stalls, the held status waits in the result
// register; a byte that produces no result still moves through, and a byte
// that would produce a result waits in the input register, which then drops
// chars.ready until the result slot frees.
// Reset clears the valid flags and returns the checker to its start state.
module email_local_part_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	lpv_in_if.sink      chars,
	lpv_out_if.source   result
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;
	logic                 empty_s1;
	lpv_pkg::lpv_state_t  state_q;
	lpv_pkg::lpv_state_t  state_nxt;
	lpv_pkg::lpv_result_t step_res;
	logic                 out_valid_q;
	logic [3:0]           status_q;
	logic                 out_free;
	logic                 advance_s1;

	assign out_free   = !out_valid_q || result.ready;
	assign advance_s1 = valid_s1 && (!step_res.has_result || out_free);
	assign chars.ready = !valid_s1 || advance_s1;

	assign result.valid  = out_valid_q;
	assign result.status = status_q;

	lpv_step u_step (
		.st           (state_q),
		.data_byte    (data_s1),
		.last_byte    (last_s1),
		.empty_string (empty_s1),
		.nxt          (state_nxt),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			data_s1  <= chars.data_byte;
			last_s1  <= chars.last_byte;
			empty_s1 <= chars.empty_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpv_pkg::STATE_RESET;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && step_res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && step_res.has_result) begin
			status_q <= step_res.status;
		end
	end

	// A finished local part always leaves the checker in its start state.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && step_res.has_result |=> state_q == lpv_pkg::STATE_RESET)
		else $error("checker state not returned to start after a result");

	// A latched error survives every byte that is not the end of a local part.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !step_res.has_result && state_q.error_code != lpv_pkg::ST_OK
		|=> $stable(state_q.error_code))
		else $error("latched error changed before the final byte");

	// Input back-pressure only arises from a result that cannot be stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && step_res.has_result && out_valid_q && !result.ready)
		else $error("input stalled without a blocked result");

	// Only defined status codes are offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q <= lpv_pkg::ST_UNCLOSED)
		else $error("undefined status code offered");

	// A stored result is not overwritten while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(status_q))
		else $error("pending result lost or changed");

endmodule

FILE: bench/lpv_tb_pkg.sv
// Status tracker for the local-part validator bench: predicts the status of each
// local part from the bytes taken and checks the statuses returned by the block.
// Depends on lpv_pkg for the status codes and character constants.
package lpv_tb_pkg;

	class status_tracker;
		logic [3:0] pending_status[$];
		int         failures;

		// Checker state for the local part now being received.
		logic       quoted;
		logic       escaped;
		logic [1:0] fold;
		logic       at_start;
		logic       dot_prev;
		logic       nul_seen;
		logic [3:0] err;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			quoted   = 1'b0;
			escaped  = 1'b0;
			fold     = lpv_pkg::FOLD_NONE;
			at_start = 1'b1;
			dot_prev = 1'b0;
			nul_seen = 1'b0;
			err      = lpv_pkg::ST_OK;
		endfunction

		// Called for each accepted input transaction.
		function void take_byte(logic [7:0] c, logic last, logic empty);
			logic       first;
			logic       after_dot;
			logic [3:0] st;
			if (empty) begin
				restart();
				pending_status.push_back(lpv_pkg::ST_EMPTY);
				return;
			end
			if (err == lpv_pkg::ST_OK && !nul_seen) begin
				first     = at_start;
				after_dot = dot_prev;
				at_start  = 1'b0;
				dot_prev  = 1'b0;
				if (fold == lpv_pkg::FOLD_WANTLF) begin
					if (c == lpv_pkg::CH_LF && !last)
						fold = lpv_pkg::FOLD_WANTWS;
					else
						err = lpv_pkg::ST_FOLD;
				end else if (fold != lpv_pkg::FOLD_NONE) begin
					if (c == lpv_pkg::CH_SP || c == lpv_pkg::CH_HT)
						fold = lpv_pkg::FOLD_NONE;
					else
						err = lpv_pkg::ST_FOLD;
				end else if (c == lpv_pkg::CH_NUL) begin
					nul_seen = 1'b1;
				end else if (c > lpv_pkg::CH_DEL) begin
					err = lpv_pkg::ST_NONASCII;
				end else begin
					// A dot is remembered even inside quotes.
					dot_prev = (c == lpv_pkg::CH_DOT);
					if (!quoted) begin
						if (c < lpv_pkg::CH_SP || c == lpv_pkg::CH_DEL) begin
							err = lpv_pkg::ST_CTRL;
						end else if (c == lpv_pkg::CH_QUOTE) begin
							if (first || after_dot)
								quoted = 1'b1;
							else
								err = lpv_pkg::ST_QUOTE;
						end else if (c == lpv_pkg::CH_DOT) begin
							if (after_dot)
								err = lpv_pkg::ST_DOTDOT;
							else if (first || last)
								err = lpv_pkg::ST_DOT;
						end else begin
							case (c)
								"(", ")", "<", ">", "@", ",", ";", ":",
								lpv_pkg::CH_BSLASH, "[", "]",
								lpv_pkg::CH_SP: err = lpv_pkg::ST_SPECIAL;
								default: ;
							endcase
						end
					end else if (escaped) begin
						escaped = 1'b0;
					end else if (c == lpv_pkg::CH_QUOTE) begin
						quoted = 1'b0;
					end else if (c == lpv_pkg::CH_BSLASH) begin
						escaped = 1'b1;
					end else if (c == lpv_pkg::CH_CR) begin
						if (last)
							err = lpv_pkg::ST_FOLD;
						else
							fold = lpv_pkg::FOLD_WANTLF;
					end
				end
			end
			if (last) begin
				if (err != lpv_pkg::ST_OK)
					st = err;
				else if (fold != lpv_pkg::FOLD_NONE)
					st = lpv_pkg::ST_FOLD;
				else if (quoted)
					st = lpv_pkg::ST_UNCLOSED;
				else
					st = lpv_pkg::ST_OK;
				restart();
				pending_status.push_back(st);
			end
		endfunction

		// Called for each accepted result transaction.
		function void match_status(logic [3:0] got);
			logic [3:0] want;
			if (pending_status.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("status %0d arrived with none outstanding", got);
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= 10)
						$display("status mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int outstanding();
			return pending_status.size();
		endfunction
	endclass

endpackage

FILE: bench/email_local_part_validator_unit_tb.sv
// Bench for email_local_part_validator_unit: directed local parts, then random
// ones with idling on both channels. Depends on lpv_pkg, lpv_in_if, lpv_out_if
// and lpv_tb_pkg.
module email_local_part_validator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1800;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [7:0] CH_A  = "a";
	localparam logic [7:0] CH_AT = "@";
	localparam logic [7:0] ODD_BYTES [12] = '{lpv_pkg::CH_NUL, lpv_pkg::CH_HT,
		lpv_pkg::CH_LF, lpv_pkg::CH_CR, lpv_pkg::CH_SP, lpv_pkg::CH_QUOTE,
		lpv_pkg::CH_DOT, lpv_pkg::CH_BSLASH, lpv_pkg::CH_DEL, 8'h80, CH_AT, "("};
	localparam string ATEXT = "abcxyzABZ0189!#$%&'*+-/=?^_{|}~";

	logic clk;
	logic arst_n;
	lpv_in_if  chars_if();
	lpv_out_if result_if();

	lpv_tb_pkg::status_tracker sb = new();
	logic [7:0]    part_q[$];
	int            sent = 0;
	bit            idle_on = 1'b1;
	int            hold_request = 0;

	email_local_part_validator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result receiver: random stall bursts, plus one long hold on request.
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready)
				sb.match_status(result_if.status);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transaction for %0d cycles", QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic l, input logic e);
		chars_if.valid        <= 1'b1;
		chars_if.data_byte    <= b;
		chars_if.last_byte    <= l;
		chars_if.empty_string <= e;
		do @(posedge clk); while (!chars_if.ready);
		sb.take_byte(b, l, e);
		sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			chars_if.valid     <= 1'b0;
			chars_if.data_byte <= 8'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Sends part_q as one local part; when cut, only a prefix is sent and an
	// empty item then abandons it.
	task automatic send_part(input bit cut);
		int n;
		n = cut ? $urandom_range(1, part_q.size()) : part_q.size();
		for (int i = 0; i < n; i++)
			send_item(part_q[i], !cut && i == n - 1, 1'b0);
		if (cut)
			send_item(8'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// Mostly well-formed dot-separated atoms and quoted strings, some with one
	// byte corrupted, the rest raw noise.
	function automatic void build_part();
		int         mode;
		int         words;
		int         k;
		logic [7:0] c;
		part_q.delete();
		mode = $urandom_range(0, 99);
		if (mode >= 85) begin
			repeat ($urandom_range(1, 6))
				part_q.push_back($urandom_range(0, 1) ? 8'($urandom)
					: ODD_BYTES[$urandom_range(0, 11)]);
			return;
		end
		words = $urandom_range(1, 3);
		for (int w = 0; w < words; w++) begin
			if (w > 0)
				part_q.push_back(lpv_pkg::CH_DOT);
			if ($urandom_range(0, 3) == 0) begin
				part_q.push_back(lpv_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 4)) begin
					k = $urandom_range(0, 7);
					if (k == 6) begin
						part_q.push_back(lpv_pkg::CH_BSLASH);
						part_q.push_back(8'($urandom_range(1, 127)));
					end else if (k == 7) begin
						part_q.push_back(lpv_pkg::CH_CR);
						part_q.push_back(lpv_pkg::CH_LF);
						part_q.push_back($urandom_range(0, 1) ? lpv_pkg::CH_SP
							: lpv_pkg::CH_HT);
					end else begin
						c = 8'($urandom_range(32, 126));
						if (c == lpv_pkg::CH_QUOTE || c == lpv_pkg::CH_BSLASH)
							c = lpv_pkg::CH_SP;
						part_q.push_back(c);
					end
				end
				if ($urandom_range(0, 9) != 0)
					part_q.push_back(lpv_pkg::CH_QUOTE);
			end else begin
				repeat ($urandom_range(1, 4))
					part_q.push_back(ATEXT[$urandom_range(0, ATEXT.len() - 1)]);
			end
		end
		if (mode >= 70)
			part_q[$urandom_range(0, part_q.size() - 1)] = $urandom_range(0, 1)
				? ODD_BYTES[$urandom_range(0, 11)] : 8'($urandom);
	endfunction

	initial begin
		int r;
		bit held;
		bit paused;
		held   = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		chars_if.valid        = 1'b0;
		chars_if.data_byte    = 8'h00;
		chars_if.last_byte    = 1'b0;
		chars_if.empty_string = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed local parts; empty wins over last_byte.
		send_item(8'hA5, 1'b1, 1'b1);
		part_q = {CH_A};                 send_part(1'b0);
		part_q = {8'hFF};                send_part(1'b0);
		part_q = {lpv_pkg::CH_DOT};      send_part(1'b0);
		part_q = {CH_A, lpv_pkg::CH_DOT}; send_part(1'b0);
		part_q = {lpv_pkg::CH_QUOTE, lpv_pkg::CH_CR, lpv_pkg::CH_LF, lpv_pkg::CH_HT,
			lpv_pkg::CH_BSLASH, lpv_pkg::CH_QUOTE, lpv_pkg::CH_QUOTE};
		send_part(1'b0);
		part_q = {CH_A, lpv_pkg::CH_DOT, lpv_pkg::CH_DOT}; send_part(1'b0);
		part_q = {CH_A, lpv_pkg::CH_QUOTE};       send_part(1'b0);
		part_q = {lpv_pkg::CH_QUOTE, lpv_pkg::CH_NUL, CH_A}; send_part(1'b0);
		part_q = {lpv_pkg::CH_DEL};      send_part(1'b0);
		part_q = {CH_AT};                send_part(1'b0);
		part_q = {lpv_pkg::CH_QUOTE, lpv_pkg::CH_CR}; send_part(1'b0);
		send_item(CH_A, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);

		while (sent < ITEMS) begin
			idle_on = !(sent >= 400 && sent < 600) && sent < 1500;
			if (!held && sent >= 300) begin
				held = 1'b1;
				hold_request = 80;
			end
			if (!paused && sent >= 900) begin
				paused = 1'b1;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(8'($urandom), 1'($urandom), 1'b1);
			end else begin
				build_part();
				send_part(r < 7);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
